// File: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console character writer
// Request structs, cell codes, register indexes and default geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default geometry and tab spacing
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 32;
  localparam int TAB_STOP_DEF    = 8;

  // Character codes with a meaning of their own
  localparam logic [7:0] CODE_BS    = 8'h08;
  localparam logic [7:0] CODE_TAB   = 8'h09;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_BLANK = 8'h20;

  // Request functions
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

  // Configuration reset values
  localparam logic [7:0] ATTR_RST = 8'h30;
  localparam logic [7:0] COLS_RST = 8'd80;
  localparam logic [5:0] ROWS_RST = 6'd25;

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [11:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [11:0] cursor_offset;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_item_t;

  // Decisions of the cursor unit for one put
  typedef struct packed {
    logic wr_en;
    logic scroll;
  } put_flags_t;

endpackage

// File: sv/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram: cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int DEPTH  = tcw_pkg::MAX_COLUMNS_DEF * tcw_pkg::MAX_ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/tcw_cursor_calc.sv
// ----------------------------------------------------------------------------
// tcw_cursor_calc: cursor update for one put
// Saturates the cursor to the screen, applies the character and reports
// where a printable code lands and whether the screen must scroll.
// ----------------------------------------------------------------------------
module tcw_cursor_calc #(
  parameter int MAX_COLUMNS = tcw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tcw_pkg::MAX_ROWS_DEF,
  parameter int TAB_STOP    = tcw_pkg::TAB_STOP_DEF
) (
  input  logic [$clog2(MAX_COLUMNS)-1:0]   cur_col,
  input  logic [$clog2(MAX_ROWS)-1:0]      cur_row,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0] cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]    rows,
  input  logic [7:0]                       code,
  output logic [$clog2(MAX_COLUMNS)-1:0]   next_col,
  output logic [$clog2(MAX_ROWS)-1:0]      next_row,
  output logic [$clog2(MAX_COLUMNS)-1:0]   wr_col,
  output logic [$clog2(MAX_ROWS)-1:0]      wr_row,
  output tcw_pkg::put_flags_t              flags
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int XW     = CNT_W + 5;
  localparam int YW     = RCNT_W + 1;
  localparam int RECIP  = (65536 + TAB_STOP - 1) / TAB_STOP;
  localparam int PW     = XW + 17;

  logic [XW-1:0] xs;
  logic [YW-1:0] ys;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [PW-1:0] prod;
  logic [XW:0]   quot;
  logic [XW-1:0] tab_x;

  // Saturate the cursor to the current geometry
  always_comb begin
    xs = (XW'(cur_col) >= XW'(cols)) ? XW'(cols) - XW'(1) : XW'(cur_col);
    ys = (YW'(cur_row) >= YW'(rows)) ? YW'(rows) - YW'(1) : YW'(cur_row);
  end

  // Next tab stop: quotient by reciprocal multiply, exact for narrow columns
  always_comb begin
    prod  = PW'(xs) * PW'(RECIP);
    quot  = prod[PW-1:16];
    tab_x = XW'((32'(quot) + 32'd1) * 32'(TAB_STOP));
  end

  // Apply the character, then wrap and scroll
  always_comb begin
    x            = xs;
    y            = ys;
    flags.wr_en  = 1'b0;
    flags.scroll = 1'b0;
    case (code)
      tcw_pkg::CODE_BS: begin
        if (x != '0) begin
          x = x - XW'(1);
        end
      end
      tcw_pkg::CODE_TAB: begin
        x = tab_x;
      end
      tcw_pkg::CODE_CR: begin
        x = '0;
      end
      tcw_pkg::CODE_LF: begin
        x = '0;
        y = y + YW'(1);
      end
      default: begin
        if (code >= tcw_pkg::CODE_BLANK) begin
          flags.wr_en = 1'b1;
          x = x + XW'(1);
        end
      end
    endcase
    if (x >= XW'(cols)) begin
      x = '0;
      y = y + YW'(1);
    end
    if (y >= YW'(rows)) begin
      flags.scroll = 1'b1;
      y = YW'(rows) - YW'(1);
    end
    next_col = COL_W'(x);
    next_row = ROW_W'(y);
    wr_col   = COL_W'(xs);
    wr_row   = ROW_W'(ys);
  end

endmodule

// File: sv/text_console_character_writer.sv
// ----------------------------------------------------------------------------
// text_console_character_writer: text console with cell store and cursor
// Puts characters, moves the cursor, scrolls and reads back stored cells.
// ----------------------------------------------------------------------------
// A read or a put passes through CALC, ADDR, WRITE and FINISH from request accept
// to result valid. A put that scrolls also passes through COPY and FILL for the row
// copy and the blank fill through the single write port of the cell store.
// A new request is taken only in IDLE, after the previous result is registered.
// Reset: a clearing pass writes zero to all MAX_COLUMNS * MAX_ROWS cells,
// one per cycle; requests wait until it ends.
module text_console_character_writer #(
  parameter int MAX_COLUMNS = tcw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tcw_pkg::MAX_ROWS_DEF,
  parameter int TAB_STOP    = tcw_pkg::TAB_STOP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tcw_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tcw_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CALC, ST_ADDR, ST_WRITE, ST_COPY, ST_FILL, ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t  out_r, out_nxt;
  logic [7:0]          attr_r;
  logic [7:0]          cols_cfg_r;
  logic [5:0]          rows_cfg_r;
  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;

  tcw_pkg::in_item_t   item_r, item_nxt;
  tcw_pkg::put_flags_t flags_r, flags_nxt;
  logic [COL_W-1:0]    nx_r, nx_nxt;
  logic [ROW_W-1:0]    ny_r, ny_nxt;
  logic [COL_W-1:0]    wcol_r, wcol_nxt;
  logic [ROW_W-1:0]    wrow_r, wrow_nxt;
  logic [ADDR_W-1:0]   waddr_r, waddr_nxt;
  logic [ADDR_W-1:0]   off_r, off_nxt;
  logic                oob_r, oob_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [ADDR_W-1:0]   src_r, src_nxt;
  logic [ADDR_W-1:0]   dst_r, dst_nxt;
  logic [COL_W-1:0]    scol_r, scol_nxt;
  logic [RCNT_W-1:0]   srow_r, srow_nxt;
  logic                pend_r, pend_nxt;

  logic [CNT_W-1:0]    cols_eff;
  logic [RCNT_W-1:0]   rows_eff;
  logic [COL_W-1:0]    calc_col;
  logic [ROW_W-1:0]    calc_row;
  logic [COL_W-1:0]    calc_wcol;
  logic [ROW_W-1:0]    calc_wrow;
  tcw_pkg::put_flags_t calc_flags;
  logic                copy_rd;
  logic                col_last;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [15:0]         ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [15:0]         ram_rdata;

  // Effective geometry
  always_comb begin
    if (cols_cfg_r == 8'd0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CNT_W'(cols_cfg_r);
    end
    if (rows_cfg_r == 6'd0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(rows_cfg_r);
    end
  end

  // Configuration writes are taken at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r     <= tcw_pkg::ATTR_RST;
      cols_cfg_r <= tcw_pkg::COLS_RST;
      rows_cfg_r <= tcw_pkg::ROWS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tcw_pkg::CFG_ATTR: attr_r     <= cfg_data;
        tcw_pkg::CFG_COLS: cols_cfg_r <= cfg_data;
        tcw_pkg::CFG_ROWS: rows_cfg_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  tcw_cursor_calc #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .TAB_STOP   (TAB_STOP)
  ) u_cursor (
    .cur_col (cur_col_r),
    .cur_row (cur_row_r),
    .cols    (cols_eff),
    .rows    (rows_eff),
    .code    (item_r.char_code),
    .next_col(calc_col),
    .next_row(calc_row),
    .wr_col  (calc_wcol),
    .wr_row  (calc_wrow),
    .flags   (calc_flags)
  );

  tcw_cell_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign copy_rd  = (srow_r < rows_eff);
  assign col_last = (CNT_W'(scol_r) == cols_eff - CNT_W'(1));

  // Cell store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = src_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_CALC: begin
        ram_re    = (item_r.func == tcw_pkg::FUNC_READ);
        ram_raddr = ADDR_W'(item_r.read_address);
      end
      ST_WRITE: begin
        ram_we    = flags_r.wr_en;
        ram_waddr = waddr_r;
        ram_wdata = {attr_r, item_r.char_code};
      end
      ST_COPY: begin
        ram_we = pend_r;
        ram_re = copy_rd;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {attr_r, tcw_pkg::CODE_BLANK};
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    item_nxt      = item_r;
    flags_nxt     = flags_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    wcol_nxt      = wcol_r;
    wrow_nxt      = wrow_r;
    waddr_nxt     = waddr_r;
    off_nxt       = off_r;
    oob_nxt       = oob_r;
    clr_nxt       = clr_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    scol_nxt      = scol_r;
    srow_nxt      = srow_r;
    pend_nxt      = pend_r;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (item_r.func == tcw_pkg::FUNC_READ) begin
          nx_nxt    = cur_col_r;
          ny_nxt    = cur_row_r;
          flags_nxt = '0;
        end else begin
          nx_nxt    = calc_col;
          ny_nxt    = calc_row;
          flags_nxt = calc_flags;
        end
        wcol_nxt  = calc_wcol;
        wrow_nxt  = calc_wrow;
        oob_nxt   = (32'(item_r.read_address) >= 32'(DEPTH));
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        waddr_nxt = ADDR_W'(32'(wrow_r) * 32'(cols_eff) + 32'(wcol_r));
        off_nxt   = ADDR_W'(32'(ny_r) * 32'(cols_eff) + 32'(nx_r));
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cur_col_nxt = nx_r;
        cur_row_nxt = ny_r;
        src_nxt     = ADDR_W'(cols_eff);
        dst_nxt     = '0;
        scol_nxt    = '0;
        srow_nxt    = RCNT_W'(1);
        pend_nxt    = 1'b0;
        state_nxt   = flags_r.scroll ? ST_COPY : ST_FINISH;
      end
      ST_COPY: begin
        // Write the row below one row up, read the next source cell
        if (pend_r) begin
          dst_nxt = dst_r + ADDR_W'(1);
        end
        pend_nxt = copy_rd;
        if (copy_rd) begin
          src_nxt = src_r + ADDR_W'(1);
          if (col_last) begin
            scol_nxt = '0;
            srow_nxt = srow_r + RCNT_W'(1);
          end else begin
            scol_nxt = scol_r + COL_W'(1);
          end
        end else if (!pend_r) begin
          scol_nxt  = '0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        // Blank the bottom row
        dst_nxt  = dst_r + ADDR_W'(1);
        scol_nxt = scol_r + COL_W'(1);
        if (col_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.cursor_column = 7'(nx_r);
          out_nxt.cursor_row    = 5'(ny_r);
          out_nxt.cursor_offset = 12'(off_r);
          out_nxt.cell_data     = (item_r.func == tcw_pkg::FUNC_READ && !oob_r) ?
                                  ram_rdata : 16'd0;
          out_nxt.scrolled      = flags_r.scroll;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, cursor and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      clr_r       <= clr_nxt;
    end
  end

  // Hold request payload and scroll pointers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    flags_r <= flags_nxt;
    nx_r    <= nx_nxt;
    ny_r    <= ny_nxt;
    wcol_r  <= wcol_nxt;
    wrow_r  <= wrow_nxt;
    waddr_r <= waddr_nxt;
    off_r   <= off_nxt;
    oob_r   <= oob_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    scol_r  <= scol_nxt;
    srow_r  <= srow_nxt;
    pend_r  <= pend_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: tb/tb_text_console_character_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_character_writer: self-checking bench for the console writer
// Drives put and read requests through bursty valid/ready traffic, mirrors
// the cell store and cursor in a local console model, and compares every
// returned report field by field. Geometry and attribute change between
// idle phases, including zero, oversized and shrinking screen sizes.
// ----------------------------------------------------------------------------
module tb_text_console_character_writer;

  localparam int STORE_DEPTH = tcw_pkg::MAX_COLUMNS_DEF * tcw_pkg::MAX_ROWS_DEF;
  localparam logic [tcw_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int TIMEOUT_TICKS = 60_000_000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tcw_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  tcw_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  // Console model: registers, cursor and cell store
  logic [7:0] con_attr;
  logic [7:0] con_cols;
  logic [5:0] con_rows;
  logic [6:0] cur_col;
  logic [4:0] cur_row;
  logic [15:0] cell_mem [0:STORE_DEPTH-1];

  tcw_pkg::in_item_t pending_requests [$];
  tcw_pkg::out_item_t expected_reports [$];
  tcw_pkg::out_item_t oldest_report;
  int queued_total;
  int accepted_total;
  int error_count;
  logic in_taken;
  int burst_left;
  int gap_left;
  logic [6:0] stall_count;

  text_console_character_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp the column register to the usable range
  function automatic int active_columns();
    int c;
    c = con_cols;
    if (c == 0) c = 1;
    if (c > tcw_pkg::MAX_COLUMNS_DEF) c = tcw_pkg::MAX_COLUMNS_DEF;
    return c;
  endfunction

  // Clamp the row register to the usable range
  function automatic int active_rows();
    int r;
    r = con_rows;
    if (r == 0) r = 1;
    if (r > tcw_pkg::MAX_ROWS_DEF) r = tcw_pkg::MAX_ROWS_DEF;
    return r;
  endfunction

  // Apply one request to the console model and return its report
  function automatic tcw_pkg::out_item_t advance_console(tcw_pkg::in_item_t req);
    int ncols;
    int nrows;
    int x;
    int y;
    int keep;
    tcw_pkg::out_item_t rep;
    ncols = active_columns();
    nrows = active_rows();
    rep = '0;
    if (req.func == tcw_pkg::FUNC_READ) begin
      if (req.read_address < STORE_DEPTH) rep.cell_data = cell_mem[req.read_address];
    end else begin
      // saturate a cursor left outside a shrunk screen
      x = cur_col;
      y = cur_row;
      if (x >= ncols) x = ncols - 1;
      if (y >= nrows) y = nrows - 1;
      if (req.char_code == tcw_pkg::CODE_BS) begin
        if (x != 0) x = x - 1;
      end else if (req.char_code == tcw_pkg::CODE_TAB) begin
        x = x + tcw_pkg::TAB_STOP_DEF - (x % tcw_pkg::TAB_STOP_DEF);
      end else if (req.char_code == tcw_pkg::CODE_CR) begin
        x = 0;
      end else if (req.char_code == tcw_pkg::CODE_LF) begin
        x = 0;
        y = y + 1;
      end else if (req.char_code >= tcw_pkg::CODE_BLANK) begin
        cell_mem[y * ncols + x] = {con_attr, req.char_code};
        x = x + 1;
      end
      // wrap at the right edge
      if (x >= ncols) begin
        x = 0;
        y = y + 1;
      end
      // scroll up one row and blank the bottom row
      if (y >= nrows) begin
        keep = (nrows - 1) * ncols;
        for (int i = 0; i < keep; i++) cell_mem[i] = cell_mem[i + ncols];
        for (int i = 0; i < ncols; i++) cell_mem[keep + i] = {con_attr, tcw_pkg::CODE_BLANK};
        y = nrows - 1;
        rep.scrolled = 1'b1;
      end
      cur_col = 7'(x);
      cur_row = 5'(y);
    end
    rep.cursor_column = cur_col;
    rep.cursor_row = cur_row;
    rep.cursor_offset = 12'(cur_row * ncols + cur_col);
    return rep;
  endfunction

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
  endtask

  // Check results, track register writes, predict accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          oldest_report = expected_reports.pop_front();
          if (out_data.cursor_column !== oldest_report.cursor_column)
            report_field("cursor_column", 16'(oldest_report.cursor_column),
                         16'(out_data.cursor_column));
          if (out_data.cursor_row !== oldest_report.cursor_row)
            report_field("cursor_row", 16'(oldest_report.cursor_row),
                         16'(out_data.cursor_row));
          if (out_data.cursor_offset !== oldest_report.cursor_offset)
            report_field("cursor_offset", 16'(oldest_report.cursor_offset),
                         16'(out_data.cursor_offset));
          if (out_data.cell_data !== oldest_report.cell_data)
            report_field("cell_data", oldest_report.cell_data, out_data.cell_data);
          if (out_data.scrolled !== oldest_report.scrolled)
            report_field("scrolled", 16'(oldest_report.scrolled), 16'(out_data.scrolled));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcw_pkg::CFG_ATTR: con_attr = cfg_data;
          tcw_pkg::CFG_COLS: con_cols = cfg_data;
          tcw_pkg::CFG_ROWS: con_rows = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_reports.push_back(advance_console(in_data));
        accepted_total++;
      end
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // Feed requests in bursts separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_requests.size() > 0) begin
      in_data <= pending_requests.pop_front();
      in_valid <= 1'b1;
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result channel: open, coin flip, fixed pattern, sparse
  always @(negedge clk) begin
    stall_count = stall_count + 7'd1;
    case (stall_count[6:5])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (stall_count[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  task automatic queue_request(input logic func, input logic [7:0] code,
                               input logic [11:0] addr);
    tcw_pkg::in_item_t req;
    req.func = func;
    req.char_code = code;
    req.read_address = addr;
    pending_requests.push_back(req);
    queued_total++;
  endtask

  // Wait until every queued request has been answered
  task automatic wait_drained();
    do @(negedge clk);
    while (!(accepted_total == queued_total && expected_reports.size() == 0));
  endtask

  task automatic write_register(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                input logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random mix: reads mostly inside the screen, control codes, printables
  task automatic queue_random(input int count);
    int span;
    int pick;
    logic [11:0] addr;
    span = active_columns() * active_rows();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      addr = 12'($urandom_range(0, STORE_DEPTH - 1));
      if (pick < 20) begin
        if (pick < 15) addr = 12'($urandom_range(0, span - 1));
        queue_request(tcw_pkg::FUNC_READ, 8'($urandom_range(0, 255)), addr);
      end else if (pick < 30) begin
        queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_LF, addr);
      end else if (pick < 36) begin
        queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_CR, addr);
      end else if (pick < 42) begin
        queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_BS, addr);
      end else if (pick < 50) begin
        queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_TAB, addr);
      end else if (pick < 56) begin
        queue_request(tcw_pkg::FUNC_PUT, 8'($urandom_range(0, 31)), addr);
      end else begin
        queue_request(tcw_pkg::FUNC_PUT, 8'($urandom_range(32, 255)), addr);
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows, input int count);
    write_register(tcw_pkg::CFG_ATTR, 8'($urandom_range(0, 255)));
    write_register(tcw_pkg::CFG_COLS, cols);
    write_register(tcw_pkg::CFG_ROWS, rows);
    queue_random(count);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tcw_pkg::CFG_ATTR;
    cfg_data = 8'd0;
    in_taken = 1'b0;
    stall_count = 7'd0;
    burst_left = 1;
    gap_left = 0;
    queued_total = 0;
    accepted_total = 0;
    error_count = 0;
    con_attr = tcw_pkg::ATTR_RST;
    con_cols = tcw_pkg::COLS_RST;
    con_rows = tcw_pkg::ROWS_RST;
    cur_col = '0;
    cur_row = '0;
    for (int i = 0; i < STORE_DEPTH; i++) cell_mem[i] = 16'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default geometry: cleared store, every control code, edge characters
    queue_request(tcw_pkg::FUNC_READ, 8'h00, 12'd0);
    queue_request(tcw_pkg::FUNC_READ, 8'hFF, 12'hFFF);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_BS, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, 8'h41, 12'hFFF);
    queue_request(tcw_pkg::FUNC_PUT, 8'hFF, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_BS, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_TAB, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_BLANK, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, 8'h00, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, 8'h1F, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_CR, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_LF, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, 8'h7E, 12'd0);
    queue_request(tcw_pkg::FUNC_READ, 8'h00, 12'd1);
    queue_request(tcw_pkg::FUNC_READ, 8'h00, 12'd80);

    // Oversized geometry clamps to the maximum screen
    write_register(tcw_pkg::CFG_ATTR, 8'hFF);
    write_register(tcw_pkg::CFG_COLS, 8'hFF);
    write_register(tcw_pkg::CFG_ROWS, 8'hFF);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_TAB, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_TAB, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, 8'h5A, 12'd0);
    queue_request(tcw_pkg::FUNC_READ, 8'h00, 12'd0);

    // Shrink the screen under the cursor: read holds it, put saturates it
    write_register(tcw_pkg::CFG_COLS, 8'd4);
    write_register(tcw_pkg::CFG_ROWS, 8'd1);
    queue_request(tcw_pkg::FUNC_READ, 8'h00, 12'hFFF);
    queue_request(tcw_pkg::FUNC_PUT, 8'h51, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_LF, 12'd0);

    // Zero geometry acts as a single cell; unknown index is ignored
    write_register(tcw_pkg::CFG_ATTR, 8'h00);
    write_register(tcw_pkg::CFG_COLS, 8'h00);
    write_register(tcw_pkg::CFG_ROWS, 8'h00);
    write_register(CFG_SPARE, 8'hA5);
    queue_request(tcw_pkg::FUNC_PUT, 8'h80, 12'd0);
    queue_request(tcw_pkg::FUNC_READ, 8'h00, 12'd0);
    queue_request(tcw_pkg::FUNC_PUT, tcw_pkg::CODE_BS, 12'd0);

    // Random phases, mostly small screens, a few at the extremes
    run_phase(8'd8, 8'd4, 100);
    run_phase(8'd5, 8'd3, 100);
    run_phase(8'd1, 8'd1, 40);
    run_phase(8'd16, 8'd6, 100);
    run_phase(8'd9, 8'd2, 100);
    run_phase(8'd3, 8'd7, 100);
    run_phase(8'd255, 8'd63, 60);
    run_phase(8'd80, 8'd25, 80);
    run_phase(8'd2, 8'd32, 90);
    run_phase(8'd128, 8'd1, 60);
    run_phase(8'd13, 8'd5, 100);
    run_phase(8'd7, 8'd1, 80);
    run_phase(8'd0, 8'd0, 30);
    run_phase(8'($urandom_range(1, 24)), 8'($urandom_range(1, 8)), 100);

    // Drain, then leave room for any stray result
    wait_drained();
    repeat (40) @(negedge clk);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("** text_console_character_writer: PASSED **");
    end else begin
      $display("** text_console_character_writer: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TICKS);
    $display("** text_console_character_writer: FAILED **");
    $finish;
  end

endmodule
